@@ rtl/okv_pkg.sv @@
// Shared types and constants of the ordered key/value table.
`default_nettype none
package okv_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CAP_W     = 7;
  localparam int unsigned HELD_W    = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_ASK    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MATCH = 2'd1,
    ST_APPLY = 2'd2
  } state_e;

  typedef struct packed {
    logic cmp_en;
    logic load_new;
    logic take_next;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/okv_if.sv @@
// Request, response and configuration channel interfaces.
`default_nettype none
interface okv_req_if;
  logic                      valid;
  logic                      ready;
  logic [okv_pkg::CMD_W-1:0] command;
  logic [okv_pkg::KEY_W-1:0] key;
  logic [okv_pkg::VAL_W-1:0] new_value;

  modport source (output valid, command, key, new_value, input ready);
  modport sink   (input valid, command, key, new_value, output ready);
endinterface

interface okv_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       error_flag;
  logic [okv_pkg::VAL_W-1:0]  found_value;
  logic [okv_pkg::HELD_W-1:0] entries_held;

  modport source (output valid, error_flag, found_value, entries_held, input ready);
  modport sink   (input valid, error_flag, found_value, entries_held, output ready);
endinterface

interface okv_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [okv_pkg::CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/okv_cell.sv @@
// One table slot: key, value and match flag, shifting from its upper neighbor.
`default_nettype none
module okv_cell (
  input  wire                       clk_i,
  input  wire okv_pkg::cell_ctrl_t  ctrl_i,
  input  wire                       valid_i,
  input  wire [okv_pkg::KEY_W-1:0]  cmp_key_i,
  input  wire [okv_pkg::VAL_W-1:0]  new_value_i,
  input  wire [okv_pkg::KEY_W-1:0]  next_key_i,
  input  wire [okv_pkg::VAL_W-1:0]  next_value_i,
  output logic [okv_pkg::KEY_W-1:0] key_o,
  output logic [okv_pkg::VAL_W-1:0] value_o,
  output logic                      match_o
);

  logic [okv_pkg::KEY_W-1:0] key_q;
  logic [okv_pkg::VAL_W-1:0] value_q;
  logic                      match_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp_en) begin
      match_q <= valid_i && (key_q == cmp_key_i);
    end
    if (ctrl_i.load_new) begin
      key_q   <= cmp_key_i;
      value_q <= new_value_i;
    end else if (ctrl_i.take_next) begin
      key_q   <= next_key_i;
      value_q <= next_value_i;
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign match_o = match_q;

endmodule
`default_nettype wire

@@ rtl/ordered_key_value_table_core.sv @@
// Top level: controller, result register and the chain of table cells.
//
//  channel  | dir | carries                                  | accepted when
//  req_i    | in  | command, key, new_value                  | valid && ready
//  rsp_o    | out | error_flag, found_value, entries_held    | valid && ready
//  cfg_i    | in  | data (capacity limit)                    | valid && ready
//
// Each item passes a match state, in which every cell compares its key and
// latches a match flag, then an apply state, in which the cells shift or load
// and the result is registered. The next item is taken in the apply state.
// Reset clears the count and restores the default limit; slots need no clearing pass.
// A stalled result holds the item in its apply state until the register frees.
`default_nettype none
module ordered_key_value_table_core #(
  parameter int unsigned TABLE_DEPTH = okv_pkg::DEPTH_DEF
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  okv_req_if.sink   req_i,
  okv_rsp_if.source rsp_o,
  okv_cfg_if.sink   cfg_i
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LW = (CW > okv_pkg::CAP_W) ? CW : okv_pkg::CAP_W;
  localparam int unsigned HW = okv_pkg::HELD_W;
  localparam int unsigned KW = okv_pkg::KEY_W;
  localparam int unsigned VW = okv_pkg::VAL_W;
  localparam int unsigned CMW = okv_pkg::CMD_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);

  okv_pkg::state_e            state_q, state_d;
  logic [CW-1:0]              count_q, count_d;
  logic [okv_pkg::CAP_W-1:0]  cap_q;
  logic [CMW-1:0]             cmd_q;
  logic [KW-1:0]              key_q;
  logic [VW-1:0]              value_q;

  logic                       out_valid_q;
  logic                       out_err_q;
  logic [VW-1:0]              out_found_q;
  logic [HW-1:0]              out_held_q;

  logic                       out_free;
  logic                       req_accept;
  logic                       cmp_en;
  logic                       apply_en;
  logic                       hit;
  logic                       add_ok, rem_ok, ask_ok;
  logic [VW-1:0]              sel_value;

  logic [TABLE_DEPTH-1:0]     match_vec;
  logic [KW-1:0]              cell_key   [TABLE_DEPTH];
  logic [VW-1:0]              cell_value [TABLE_DEPTH];

  assign out_free   = !out_valid_q || rsp_o.ready;
  assign req_accept = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      okv_pkg::ST_IDLE:  if (req_accept) state_d = okv_pkg::ST_MATCH;
      okv_pkg::ST_MATCH: state_d = okv_pkg::ST_APPLY;
      okv_pkg::ST_APPLY: begin
        if (out_free) begin
          state_d = req_accept ? okv_pkg::ST_MATCH : okv_pkg::ST_IDLE;
        end
      end
      default: state_d = okv_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req_i.ready = 1'b0;
    cmp_en      = 1'b0;
    apply_en    = 1'b0;
    unique case (state_q)
      okv_pkg::ST_IDLE:  req_i.ready = 1'b1;
      okv_pkg::ST_MATCH: cmp_en = 1'b1;
      okv_pkg::ST_APPLY: begin
        req_i.ready = out_free;
        apply_en    = out_free;
      end
      default: ;
    endcase
  end

  // decide
  always_comb begin
    hit       = |match_vec;
    add_ok    = (cmd_q == okv_pkg::CMD_ADD) && !hit &&
                (LW'(count_q) < LW'(cap_q)) && (LW'(count_q) < DEPTH_L);
    rem_ok    = (cmd_q == okv_pkg::CMD_REMOVE) && hit;
    ask_ok    = (cmd_q == okv_pkg::CMD_ASK) && hit;
    sel_value = '0;
    for (int unsigned j = 0; j < TABLE_DEPTH; j++) begin
      sel_value = sel_value | (match_vec[j] ? cell_value[j] : '0);
    end
    count_d = count_q;
    if (add_ok) begin
      count_d = count_q + CW'(1);
    end else if (rem_ok) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= okv_pkg::ST_IDLE;
      count_q     <= '0;
      cap_q       <= okv_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        cap_q <= cfg_i.data;
      end
      if (apply_en) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      cmd_q   <= req_i.command;
      key_q   <= req_i.key;
      value_q <= req_i.new_value;
    end
    if (apply_en) begin
      out_err_q   <= !(add_ok || rem_ok || ask_ok);
      out_found_q <= ask_ok ? sel_value : '0;
      out_held_q  <= HW'(count_d);
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.error_flag   = out_err_q;
  assign rsp_o.found_value  = out_found_q;
  assign rsp_o.entries_held = out_held_q;

  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    okv_pkg::cell_ctrl_t ctrl;
    logic [KW-1:0]       nxt_key;
    logic [VW-1:0]       nxt_value;

    if (j + 1 < TABLE_DEPTH) begin : g_mid
      assign nxt_key   = cell_key[j+1];
      assign nxt_value = cell_value[j+1];
      assign ctrl.take_next = apply_en && rem_ok && (|match_vec[j:0]);
    end else begin : g_last
      assign nxt_key   = '0;
      assign nxt_value = '0;
      assign ctrl.take_next = 1'b0;
    end
    assign ctrl.cmp_en   = cmp_en;
    assign ctrl.load_new = apply_en && add_ok && (count_q == CW'(j));

    okv_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (LW'(count_q) > LW'(j)),
      .cmp_key_i    (key_q),
      .new_value_i  (value_q),
      .next_key_i   (nxt_key),
      .next_value_i (nxt_value),
      .key_o        (cell_key[j]),
      .value_o      (cell_value[j]),
      .match_o      (match_vec[j])
    );
  end

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == okv_pkg::ST_APPLY) |-> $onehot0(match_vec))
    else $error("more than one slot matches the key");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(count_q) <= DEPTH_L)
    else $error("entry count beyond table depth");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (apply_en && add_ok) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("accepted add did not grow the count");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply_en |=> out_valid_q)
    else $error("applied item left no result");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the ordered key/value table core.
module tb;

  localparam int unsigned DEPTH        = okv_pkg::DEPTH_DEF;
  localparam int unsigned IDLE_PCT     = 15;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned POOL_MAX     = 96;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned NUM_PHASES   = 7;

  localparam logic [okv_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [okv_pkg::KEY_W-1:0] KEY_ONES   = '1;
  localparam logic [okv_pkg::VAL_W-1:0] VAL_ONES   = '1;

  typedef struct packed {
    logic [okv_pkg::CMD_W-1:0] command;
    logic [okv_pkg::KEY_W-1:0] key;
    logic [okv_pkg::VAL_W-1:0] new_value;
  } request_t;

  typedef struct packed {
    logic                       error_flag;
    logic [okv_pkg::VAL_W-1:0]  found_value;
    logic [okv_pkg::HELD_W-1:0] entries_held;
  } answer_t;

  logic clk;
  logic rst_n;

  okv_req_if req_ch ();
  okv_rsp_if rsp_ch ();
  okv_cfg_if cfg_ch ();

  ordered_key_value_table_core #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_ch),
    .rsp_o (rsp_ch),
    .cfg_i (cfg_ch)
  );

  request_t                  pending_q[$];
  answer_t                   answer_q[$];
  logic [okv_pkg::KEY_W-1:0] slot_key[DEPTH];
  logic [okv_pkg::VAL_W-1:0] slot_val[DEPTH];
  int unsigned               held_cnt;
  int unsigned               cap_limit;
  logic                      req_fire;
  logic                      cfg_fire;
  bit                        quiet;
  int unsigned               err_cnt;
  int unsigned               cycle_cnt;
  logic [okv_pkg::KEY_W-1:0] key_pool[POOL_MAX];

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic answer_t apply_request(request_t r);
    answer_t     a;
    int unsigned lim;
    int unsigned pos;
    int unsigned j;
    a.error_flag  = 1'b1;
    a.found_value = '0;
    lim = (cap_limit > DEPTH) ? DEPTH : cap_limit;
    pos = held_cnt;
    for (j = 0; j < held_cnt; j++) begin
      if (slot_key[j] == r.key) begin
        pos = j;
        break;
      end
    end
    case (r.command)
      okv_pkg::CMD_ADD: begin
        if (pos == held_cnt && held_cnt < lim) begin
          slot_key[held_cnt] = r.key;
          slot_val[held_cnt] = r.new_value;
          held_cnt++;
          a.error_flag = 1'b0;
        end
      end
      okv_pkg::CMD_REMOVE: begin
        if (pos < held_cnt) begin
          for (j = pos; j + 1 < held_cnt; j++) begin
            slot_key[j] = slot_key[j+1];
            slot_val[j] = slot_val[j+1];
          end
          held_cnt--;
          a.error_flag = 1'b0;
        end
      end
      okv_pkg::CMD_ASK: begin
        if (pos < held_cnt) begin
          a.found_value = slot_val[pos];
          a.error_flag  = 1'b0;
        end
      end
      default: ;
    endcase
    a.entries_held = held_cnt[okv_pkg::HELD_W-1:0];
    return a;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("tb: mismatch %s got %h want %h cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  task automatic push_req(input logic [okv_pkg::CMD_W-1:0] c,
                          input logic [okv_pkg::KEY_W-1:0] k,
                          input logic [okv_pkg::VAL_W-1:0] v);
    pending_q.push_back('{command: c, key: k, new_value: v});
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
      #1;
    end while (!(pending_q.size() == 0 && !req_ch.valid && answer_q.size() == 0));
  endtask

  task automatic write_limit(input logic [okv_pkg::CAP_W-1:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(negedge clk);
    while (!cfg_fire);
    cfg_ch.valid <= 1'b0;
  endtask

  // monitor and scoreboard
  always @(posedge clk or negedge rst_n) begin : mon
    answer_t want;
    if (!rst_n) begin
      req_fire  <= 1'b0;
      cfg_fire  <= 1'b0;
      held_cnt  = 0;
      cap_limit = 32'(okv_pkg::CAP_RESET);
    end else begin
      req_fire <= req_ch.valid && req_ch.ready;
      cfg_fire <= cfg_ch.valid && cfg_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected item", rsp_ch.found_value, '0);
        end else begin
          want = answer_q.pop_front();
          if (rsp_ch.error_flag !== want.error_flag)
            report_mismatch("error_flag", 64'(rsp_ch.error_flag), 64'(want.error_flag));
          if (rsp_ch.found_value !== want.found_value)
            report_mismatch("found_value", rsp_ch.found_value, want.found_value);
          if (rsp_ch.entries_held !== want.entries_held)
            report_mismatch("entries_held", 64'(rsp_ch.entries_held),
                            64'(want.entries_held));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) cap_limit = 32'(cfg_ch.data);
      if (req_ch.valid && req_ch.ready)
        answer_q.push_back(apply_request('{command: req_ch.command, key: req_ch.key,
                                           new_value: req_ch.new_value}));
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // request driver and response back-pressure
  always @(negedge clk) begin : drive
    request_t r;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (req_fire || !req_ch.valid) begin
        if (pending_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          r = pending_q.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.command   <= r.command;
          req_ch.key       <= r.key;
          req_ch.new_value <= r.new_value;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      rsp_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin : stim
    int unsigned               phase_limit[NUM_PHASES] = '{127, 64, 5, 0, 40, 64, 127};
    int unsigned               phase_pool[NUM_PHASES]  = '{96, 96, 12, 12, 64, 8, 96};
    int unsigned               phase_add[NUM_PHASES]   = '{80, 45, 45, 45, 45, 50, 40};
    int unsigned               phase_items[NUM_PHASES] = '{150, 100, 100, 60, 100, 100, 100};
    int unsigned               ph;
    int unsigned               n;
    int unsigned               pct;
    logic [okv_pkg::CMD_W-1:0] c;
    logic [okv_pkg::KEY_W-1:0] k;
    logic [okv_pkg::KEY_W-1:0] k0;
    logic [okv_pkg::KEY_W-1:0] k1;
    logic [okv_pkg::KEY_W-1:0] k2;

    rst_n            = 1'b0;
    quiet            = 1'b0;
    err_cnt          = 0;
    cycle_cnt        = 0;
    req_ch.valid     = 1'b0;
    req_ch.command   = '0;
    req_ch.key       = '0;
    req_ch.new_value = '0;
    rsp_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    for (n = 0; n < POOL_MAX; n++) key_pool[n] = {$urandom, $urandom};
    k0 = key_pool[0];
    k1 = key_pool[1];
    k2 = key_pool[2];

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // misses on an empty table, then adds, duplicates, shifting removes
    push_req(okv_pkg::CMD_ASK, k0, {$urandom, $urandom});
    push_req(okv_pkg::CMD_REMOVE, k0, '0);
    push_req(CMD_UNUSED, k0, VAL_ONES);
    push_req(okv_pkg::CMD_ADD, k0, {$urandom, $urandom});
    push_req(okv_pkg::CMD_ADD, k0, {$urandom, $urandom});
    push_req(okv_pkg::CMD_ASK, k0, '0);
    push_req(okv_pkg::CMD_ADD, KEY_ONES, VAL_ONES);
    push_req(okv_pkg::CMD_ADD, '0, '0);
    push_req(okv_pkg::CMD_ADD, k1, {$urandom, $urandom});
    push_req(okv_pkg::CMD_REMOVE, k0, VAL_ONES);
    push_req(okv_pkg::CMD_ASK, KEY_ONES, '0);
    push_req(okv_pkg::CMD_ASK, '0, VAL_ONES);
    push_req(okv_pkg::CMD_ASK, k1, '0);
    push_req(okv_pkg::CMD_REMOVE, k1, '0);
    push_req(okv_pkg::CMD_ASK, k1, '0);
    push_req(CMD_UNUSED, KEY_ONES, '0);
    wait_idle();

    // limit below the count: add rejected, remove and ask still work
    write_limit(7'd1);
    push_req(okv_pkg::CMD_ADD, k2, {$urandom, $urandom});
    push_req(okv_pkg::CMD_ASK, KEY_ONES, '0);
    push_req(okv_pkg::CMD_REMOVE, '0, '0);
    push_req(okv_pkg::CMD_ADD, k2, {$urandom, $urandom});
    wait_idle();

    write_limit(7'd0);
    push_req(okv_pkg::CMD_ADD, k2, {$urandom, $urandom});
    push_req(okv_pkg::CMD_REMOVE, KEY_ONES, '0);
    push_req(okv_pkg::CMD_ADD, k2, {$urandom, $urandom});
    wait_idle();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_limit(phase_limit[ph][okv_pkg::CAP_W-1:0]);
      quiet = (ph == 1);
      for (n = 0; n < phase_items[ph]; n++) begin
        pct = $urandom_range(99);
        if (pct < phase_add[ph]) c = okv_pkg::CMD_ADD;
        else if (pct >= 95) c = CMD_UNUSED;
        else if (pct[0]) c = okv_pkg::CMD_REMOVE;
        else c = okv_pkg::CMD_ASK;
        if ($urandom_range(99) < 85) k = key_pool[$urandom_range(phase_pool[ph] - 1)];
        else k = {$urandom, $urandom};
        push_req(c, k, {$urandom, $urandom});
      end
      wait_idle();
    end
    quiet = 1'b0;

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
